>>> rtl/core/jsu_pkg.sv
package jsu_pkg;

	// Default sizes handed to the top level parameters.
	localparam int OFFSET_BITS_DEFAULT = 32;
	localparam int QUEUE_DEPTH_DEFAULT = 4;

	// Error codes reported in error_code.
	localparam logic [3:0] ERR_NONE        = 4'd0;
	localparam logic [3:0] ERR_TRUNCATED   = 4'd1;
	localparam logic [3:0] ERR_BAD_ESCAPE  = 4'd2;
	localparam logic [3:0] ERR_SHORT_U     = 4'd3;
	localparam logic [3:0] ERR_BAD_HEX     = 4'd4;
	localparam logic [3:0] ERR_LONE_LOW    = 4'd5;
	localparam logic [3:0] ERR_MISSING_LOW = 4'd6;
	localparam logic [3:0] ERR_BAD_LOW_HEX = 4'd7;
	localparam logic [3:0] ERR_LOW_RANGE   = 4'd8;

	// Characters that steer the decoder.
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_U      = 8'h75;

	// Surrogate prefixes on the top six bits of a 16-bit code unit.
	localparam logic [5:0] SURR_HIGH = 6'b110110;
	localparam logic [5:0] SURR_LOW  = 6'b110111;
	localparam logic [20:0] SUPP_BASE = 21'h10000;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        has_byte;
		logic        slice_last;
		logic [31:0] start_offset;
	} item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        out_valid;
		logic [3:0]  error_code;
		logic [31:0] error_offset;
		logic        result_last;
	} result_t;

	// One queue entry: a burst of one to four bytes, or one non-byte result.
	typedef struct packed {
		logic            is_byte;
		logic [1:0]      cnt_m1;
		logic [3:0][7:0] bytes;
		logic [3:0]      code;
		logic [31:0]     offset;
		logic            last;
	} rec_t;

	typedef struct packed {
		logic       bad;
		logic [3:0] value;
	} hex_t;

	typedef struct packed {
		logic [2:0]      count;
		logic [3:0][7:0] bytes;
	} utf8_t;

	typedef struct packed {
		logic       ok;
		logic [7:0] value;
	} esc_t;

	// Value of one hex digit; bad is set for any other character.
	function automatic hex_t hex_digit(input logic [7:0] b);
		hex_t       h;
		logic [7:0] d;
		h.bad = 1'b0;
		d     = 8'h00;
		priority if (b >= 8'h30 && b <= 8'h39) begin
			d = b - 8'h30;
		end else if (b >= 8'h61 && b <= 8'h66) begin
			d = b - 8'h57;
		end else if (b >= 8'h41 && b <= 8'h46) begin
			d = b - 8'h37;
		end else begin
			h.bad = 1'b1;
		end
		h.value = d[3:0];
		return h;
	endfunction

	// Byte produced by a simple escape letter.
	function automatic esc_t esc_letter(input logic [7:0] b);
		esc_t e;
		e.ok = 1'b1;
		unique case (b)
			8'h22: e.value = 8'h22; // quote
			8'h5C: e.value = 8'h5C; // backslash
			8'h2F: e.value = 8'h2F; // slash
			8'h62: e.value = 8'h08; // b
			8'h66: e.value = 8'h0C; // f
			8'h6E: e.value = 8'h0A; // n
			8'h72: e.value = 8'h0D; // r
			8'h74: e.value = 8'h09; // t
			default: begin
				e.ok    = 1'b0;
				e.value = 8'h00;
			end
		endcase
		return e;
	endfunction

	// UTF-8 form of a code point; bytes[0] goes out first.
	function automatic utf8_t utf8_encode(input logic [20:0] cp);
		utf8_t u;
		u.bytes = '0;
		priority if (cp < 21'h80) begin
			u.count    = 3'd1;
			u.bytes[0] = cp[7:0];
		end else if (cp < 21'h800) begin
			u.count    = 3'd2;
			u.bytes[0] = {3'b110, cp[10:6]};
			u.bytes[1] = {2'b10, cp[5:0]};
		end else if (cp < 21'h10000) begin
			u.count    = 3'd3;
			u.bytes[0] = {4'b1110, cp[15:12]};
			u.bytes[1] = {2'b10, cp[11:6]};
			u.bytes[2] = {2'b10, cp[5:0]};
		end else begin
			u.count    = 3'd4;
			u.bytes[0] = {5'b11110, cp[20:18]};
			u.bytes[1] = {2'b10, cp[17:12]};
			u.bytes[2] = {2'b10, cp[11:6]};
			u.bytes[3] = {2'b10, cp[5:0]};
		end
		return u;
	endfunction

endpackage

>>> rtl/core/jsu_stream_if.sv
interface jsu_stream_if #(
	parameter type T = logic
) ();

	logic valid;
	logic ready;
	T     payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);

endinterface

>>> rtl/core/jsu_front.sv
module jsu_front import jsu_pkg::*; #(
	parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_ready,
	input  item_t item,
	output logic  push_valid,
	input  logic  push_ready,
	output rec_t  push_rec
);

	localparam logic [2:0] MODE_PLAIN   = 3'd0;
	localparam logic [2:0] MODE_ESC     = 3'd1;
	localparam logic [2:0] MODE_UHEX    = 3'd2;
	localparam logic [2:0] MODE_LOW_BS  = 3'd3;
	localparam logic [2:0] MODE_LOW_U   = 3'd4;
	localparam logic [2:0] MODE_LOW_HEX = 3'd5;

	typedef logic [OFFSET_BITS-1:0] off_t;

	logic [2:0]  mode_q;
	logic [15:0] acc_q;
	logic [2:0]  dc_q;
	logic [9:0]  hh_q;
	off_t        cur_q;
	logic        drop_q;
	logic        start_q;
	logic        bad_q;
	off_t        mu_q;
	off_t        mh_q;

	logic [2:0]      m;
	logic [15:0]     acc;
	logic [2:0]      dc;
	logic [9:0]      hh;
	off_t            cur;
	off_t            after;
	logic            drop;
	logic            bad;
	off_t            mu;
	off_t            mh;
	hex_t            hx;
	esc_t            es;
	utf8_t           u8;
	logic            res_err;
	logic [3:0]      e_code;
	off_t            e_off;
	logic [2:0]      cnt;
	logic [3:0][7:0] bytes;

	off_t        start_sat;
	logic [31:0] off32;
	logic        fire;

	// Saturate the 32-bit slice start into the cursor width, and an error
	// offset back into 32 bits.
	if (OFFSET_BITS < 32) begin : g_narrow
		assign start_sat = (|item.start_offset[31:OFFSET_BITS]) ? '1 :
			item.start_offset[OFFSET_BITS-1:0];
	end else begin : g_wide_start
		assign start_sat = OFFSET_BITS'(item.start_offset);
	end
	if (OFFSET_BITS > 32) begin : g_wide_off
		assign off32 = (|e_off[OFFSET_BITS-1:32]) ? 32'hFFFF_FFFF : e_off[31:0];
	end else begin : g_narrow_off
		assign off32 = 32'(e_off);
	end

	// Decode one item against the current state and collect its results.
	always_comb begin
		m       = start_q ? MODE_PLAIN : mode_q;
		acc     = start_q ? '0 : acc_q;
		dc      = start_q ? '0 : dc_q;
		hh      = start_q ? '0 : hh_q;
		drop    = start_q ? 1'b0 : drop_q;
		bad     = start_q ? 1'b0 : bad_q;
		mu      = start_q ? '0 : mu_q;
		mh      = start_q ? '0 : mh_q;
		cur     = start_q ? start_sat : cur_q;
		after   = (cur == '1) ? cur : cur + 1'b1;
		hx      = hex_digit(item.data_byte);
		es      = esc_letter(item.data_byte);
		u8      = utf8_encode({5'd0, acc_q[11:0], hx.value});
		res_err = 1'b0;
		e_code  = ERR_NONE;
		e_off   = '0;
		cnt     = 3'd0;
		bytes   = '0;

		if (item.has_byte) begin
			if (!drop) begin
				unique case (m)
					MODE_PLAIN: begin
						if (item.data_byte == CH_BSLASH) begin
							m = MODE_ESC;
						end else begin
							cnt      = 3'd1;
							bytes[0] = item.data_byte;
						end
					end
					MODE_ESC: begin
						m = MODE_PLAIN;
						if (item.data_byte == CH_U) begin
							m   = MODE_UHEX;
							acc = '0;
							dc  = '0;
							bad = 1'b0;
							mu  = after;
						end else if (es.ok) begin
							cnt      = 3'd1;
							bytes[0] = es.value;
						end else begin
							res_err = 1'b1;
							e_code  = ERR_BAD_ESCAPE;
							e_off   = after;
						end
					end
					MODE_UHEX, MODE_LOW_HEX: begin
						bad = bad | hx.bad;
						acc = {acc[11:0], hx.value};
						dc  = dc + 3'd1;
						if (dc == 3'd4) begin
							if (m == MODE_UHEX) begin
								priority if (bad) begin
									res_err = 1'b1;
									e_code  = ERR_BAD_HEX;
									e_off   = mu;
								end else if (acc[15:10] == SURR_HIGH) begin
									hh = acc[9:0];
									mh = after;
									m  = MODE_LOW_BS;
								end else if (acc[15:10] == SURR_LOW) begin
									res_err = 1'b1;
									e_code  = ERR_LONE_LOW;
									e_off   = after;
								end else begin
									u8    = utf8_encode({5'd0, acc});
									cnt   = u8.count;
									bytes = u8.bytes;
									m     = MODE_PLAIN;
								end
							end else begin
								priority if (bad) begin
									res_err = 1'b1;
									e_code  = ERR_BAD_LOW_HEX;
									e_off   = mu;
								end else if (acc[15:10] != SURR_LOW) begin
									res_err = 1'b1;
									e_code  = ERR_LOW_RANGE;
									e_off   = after;
								end else begin
									// The two halves give twenty bits that sit
									// above the supplementary base.
									u8    = utf8_encode(SUPP_BASE + {1'b0, hh, acc[9:0]});
									cnt   = u8.count;
									bytes = u8.bytes;
									m     = MODE_PLAIN;
								end
							end
						end
					end
					MODE_LOW_BS: begin
						if (item.data_byte == CH_BSLASH) begin
							m = MODE_LOW_U;
						end else begin
							res_err = 1'b1;
							e_code  = ERR_MISSING_LOW;
							e_off   = mh;
						end
					end
					MODE_LOW_U: begin
						if (item.data_byte == CH_U) begin
							m   = MODE_LOW_HEX;
							acc = '0;
							dc  = '0;
							bad = 1'b0;
							mu  = after;
						end else begin
							res_err = 1'b1;
							e_code  = ERR_MISSING_LOW;
							e_off   = mh;
						end
					end
					default: begin
						m = MODE_PLAIN;
					end
				endcase
				if (res_err) begin
					drop = 1'b1;
					m    = MODE_PLAIN;
				end
			end
			cur = after;
		end

		// An escape left open at the end of the slice is an error.
		if (item.slice_last && !drop) begin
			unique case (m)
				MODE_PLAIN: begin
				end
				MODE_ESC: begin
					res_err = 1'b1;
					e_code  = ERR_TRUNCATED;
					e_off   = cur;
				end
				MODE_UHEX: begin
					res_err = 1'b1;
					e_code  = ERR_SHORT_U;
					e_off   = mu;
				end
				default: begin
					res_err = 1'b1;
					e_code  = ERR_MISSING_LOW;
					e_off   = mh;
				end
			endcase
			if (res_err) begin
				drop = 1'b1;
				m    = MODE_PLAIN;
			end
		end
	end

	// An error and the slice-end marker share the non-byte entry form.
	always_comb begin
		push_rec.is_byte = !res_err && (cnt != 3'd0);
		push_rec.cnt_m1  = push_rec.is_byte ? 2'(cnt - 3'd1) : 2'd0;
		push_rec.bytes   = bytes;
		push_rec.code    = e_code;
		push_rec.offset  = res_err ? off32 : 32'd0;
		push_rec.last    = item.slice_last;
	end

	assign push_valid = item_valid && (res_err || (cnt != 3'd0) || item.slice_last);
	assign item_ready = push_ready;
	assign fire       = item_valid && push_ready;

	// Decoder state advances on every transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_PLAIN;
			acc_q   <= '0;
			dc_q    <= '0;
			hh_q    <= '0;
			cur_q   <= '0;
			drop_q  <= 1'b0;
			start_q <= 1'b1;
			bad_q   <= 1'b0;
			mu_q    <= '0;
			mh_q    <= '0;
		end else if (fire) begin
			mode_q  <= m;
			acc_q   <= acc;
			dc_q    <= dc;
			hh_q    <= hh;
			cur_q   <= cur;
			drop_q  <= drop;
			start_q <= item.slice_last;
			bad_q   <= bad;
			mu_q    <= mu;
			mh_q    <= mh;
		end
	end

	// Once dropping, the decoder stays silent until the slice ends.
	assert property (@(posedge clk) disable iff (!arst_n)
		drop_q && !start_q && !(fire && item.slice_last) |=> drop_q)
		else $error("drop flag cleared inside a slice");

	// A result with no byte and no error only marks the end of a slice.
	assert property (@(posedge clk) disable iff (!arst_n)
		push_valid && !push_rec.is_byte && push_rec.code == ERR_NONE |-> push_rec.last)
		else $error("empty marker outside slice end");

endmodule

>>> rtl/core/jsu_queue.sv
module jsu_queue import jsu_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  rec_t push_rec,
	output logic pop_valid,
	input  logic pop_ready,
	output rec_t pop_rec
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	rec_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_rec    = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue overfilled");

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> wr_ptr_q == rd_ptr_q)
		else $error("empty queue with split pointers");

endmodule

>>> rtl/core/jsu_back.sv
module jsu_back import jsu_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    pop_valid,
	output logic    pop_ready,
	input  rec_t    pop_rec,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	logic [1:0] idx_q;
	logic       ov_q;
	result_t    res_q;
	logic       load;
	logic       final_part;

	assign load       = pop_valid && (!ov_q || result_ready);
	assign final_part = idx_q == pop_rec.cnt_m1;
	assign pop_ready  = load && final_part;

	// Output register; a burst entry is walked one byte per transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			ov_q  <= 1'b1;
			idx_q <= final_part ? 2'd0 : idx_q + 2'd1;
		end else if (result_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q.out_byte     <= pop_rec.is_byte ? pop_rec.bytes[idx_q] : 8'h00;
			res_q.out_valid    <= pop_rec.is_byte;
			res_q.error_code   <= pop_rec.code;
			res_q.error_offset <= pop_rec.offset;
			res_q.result_last  <= pop_rec.last && final_part;
		end
	end

	assign result_valid = ov_q;
	assign result       = res_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.out_valid |-> result.error_code == ERR_NONE)
		else $error("byte result carries an error code");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop_valid |-> idx_q <= pop_rec.cnt_m1)
		else $error("burst index past entry length");

endmodule

>>> rtl/core/json_string_unescape.sv
// A result reaches the output through the entry queue and then the output register.
// The input takes one item per cycle and stalls only when the entry queue (QUEUE_DEPTH
// entries) is full. The output side moves one result per cycle while the receiver is
// ready; a UTF-8 burst goes out byte by byte while the queue absorbs input.
// Reset: arst_n clears decoder state, queue pointers and the output valid flag at once.
module json_string_unescape import jsu_pkg::*; #(
	parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	jsu_stream_if.sink   item,
	jsu_stream_if.source result
);

	logic push_valid;
	logic push_ready;
	rec_t push_rec;
	logic pop_valid;
	logic pop_ready;
	rec_t pop_rec;

	// Classify bytes and run the escape decoder.
	jsu_front #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item.valid),
		.item_ready(item.ready),
		.item      (item.payload),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_rec  (push_rec)
	);

	// Decouple decoding from result delivery.
	jsu_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_rec  (push_rec),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_rec   (pop_rec)
	);

	// Serialize entries into single results.
	jsu_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_rec     (pop_rec),
		.result_valid(result.valid),
		.result_ready(result.ready),
		.result      (result.payload)
	);

endmodule

>>> tb/sv/unescape_check.sv
// Watches both channels of the unescaper, predicts the decoded stream and
// compares every result transfer against the oldest prediction.
module unescape_check import jsu_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  logic    item_ready,
	input  item_t   item_data,
	input  logic    result_valid,
	input  logic    result_ready,
	input  result_t result_data,
	output int      mismatches,
	output int      pending
);

	typedef enum logic [2:0] {
		MODE_PLAIN,
		MODE_ESC,
		MODE_UHEX,
		MODE_LOW_BS,
		MODE_LOW_U,
		MODE_LOW_HEX
	} decode_mode_e;

	// Decoder state as the block should hold it.
	decode_mode_e mode = MODE_PLAIN;
	logic [15:0]  hex_acc = '0;
	logic [2:0]   digits = '0;
	logic [9:0]   high_bits = '0;
	logic [31:0]  cursor = '0;
	logic [31:0]  mark_u = '0;
	logic [31:0]  mark_high = '0;
	logic         dropping = 1'b0;
	logic         at_slice_start = 1'b1;
	logic         hex_invalid = 1'b0;

	// Decoded results still owed by the block, oldest first.
	result_t decoded_q[$];
	result_t wanted;
	int      fail_total = 0;

	function automatic void push_result(input logic [7:0] b, input logic v,
			input logic [3:0] code, input logic [31:0] off);
		result_t r;
		r.out_byte     = b;
		r.out_valid    = v;
		r.error_code   = code;
		r.error_offset = off;
		r.result_last  = 1'b0;
		decoded_q.push_back(r);
	endfunction

	// An error result stops decoding until the slice ends.
	function automatic void raise_error(input logic [3:0] code, input logic [31:0] off);
		push_result(8'h00, 1'b0, code, off);
		dropping = 1'b1;
		mode     = MODE_PLAIN;
	endfunction

	function automatic void push_utf8(input logic [20:0] cp);
		if (cp < 21'h80) begin
			push_result(cp[7:0], 1'b1, ERR_NONE, '0);
		end else if (cp < 21'h800) begin
			push_result({3'b110, cp[10:6]}, 1'b1, ERR_NONE, '0);
			push_result({2'b10, cp[5:0]}, 1'b1, ERR_NONE, '0);
		end else if (cp < 21'h10000) begin
			push_result({4'b1110, cp[15:12]}, 1'b1, ERR_NONE, '0);
			push_result({2'b10, cp[11:6]}, 1'b1, ERR_NONE, '0);
			push_result({2'b10, cp[5:0]}, 1'b1, ERR_NONE, '0);
		end else begin
			push_result({5'b11110, cp[20:18]}, 1'b1, ERR_NONE, '0);
			push_result({2'b10, cp[17:12]}, 1'b1, ERR_NONE, '0);
			push_result({2'b10, cp[11:6]}, 1'b1, ERR_NONE, '0);
			push_result({2'b10, cp[5:0]}, 1'b1, ERR_NONE, '0);
		end
	endfunction

	// A non-hex digit counts as zero and is only flagged; it is judged after four.
	function automatic void shift_digit(input logic [7:0] b);
		logic [3:0] v;
		v = 4'h0;
		if (b >= "0" && b <= "9") begin
			v = 4'(b - "0");
		end else if (b >= "a" && b <= "f") begin
			v = 4'(b - "a" + 8'd10);
		end else if (b >= "A" && b <= "F") begin
			v = 4'(b - "A" + 8'd10);
		end else begin
			hex_invalid = 1'b1;
		end
		hex_acc = {hex_acc[11:0], v};
		digits  = digits + 3'd1;
	endfunction

	function automatic void start_digits(input logic [31:0] next_cursor);
		hex_acc     = '0;
		digits      = '0;
		hex_invalid = 1'b0;
		mark_u      = next_cursor;
	endfunction

	function automatic void clear_decoder();
		mode        = MODE_PLAIN;
		hex_acc     = '0;
		digits      = '0;
		high_bits   = '0;
		dropping    = 1'b0;
		hex_invalid = 1'b0;
		mark_u      = '0;
		mark_high   = '0;
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic [31:0] next_cursor);
		case (mode)
			MODE_PLAIN: begin
				if (b == CH_BSLASH) mode = MODE_ESC;
				else push_result(b, 1'b1, ERR_NONE, '0);
			end
			MODE_ESC: begin
				mode = MODE_PLAIN;
				case (b)
					CH_U: begin
						mode = MODE_UHEX;
						start_digits(next_cursor);
					end
					"\"": push_result(8'h22, 1'b1, ERR_NONE, '0);
					"\\": push_result(8'h5C, 1'b1, ERR_NONE, '0);
					"/": push_result(8'h2F, 1'b1, ERR_NONE, '0);
					"b": push_result(8'h08, 1'b1, ERR_NONE, '0);
					"f": push_result(8'h0C, 1'b1, ERR_NONE, '0);
					"n": push_result(8'h0A, 1'b1, ERR_NONE, '0);
					"r": push_result(8'h0D, 1'b1, ERR_NONE, '0);
					"t": push_result(8'h09, 1'b1, ERR_NONE, '0);
					default: raise_error(ERR_BAD_ESCAPE, next_cursor);
				endcase
			end
			MODE_UHEX: begin
				shift_digit(b);
				if (digits == 3'd4) begin
					if (hex_invalid) begin
						raise_error(ERR_BAD_HEX, mark_u);
					end else if (hex_acc[15:10] == SURR_HIGH) begin
						high_bits = hex_acc[9:0];
						mark_high = next_cursor;
						mode      = MODE_LOW_BS;
					end else if (hex_acc[15:10] == SURR_LOW) begin
						raise_error(ERR_LONE_LOW, next_cursor);
					end else begin
						push_utf8({5'd0, hex_acc});
						mode = MODE_PLAIN;
					end
				end
			end
			MODE_LOW_BS: begin
				if (b == CH_BSLASH) mode = MODE_LOW_U;
				else raise_error(ERR_MISSING_LOW, mark_high);
			end
			MODE_LOW_U: begin
				if (b == CH_U) begin
					mode = MODE_LOW_HEX;
					start_digits(next_cursor);
				end else begin
					raise_error(ERR_MISSING_LOW, mark_high);
				end
			end
			default: begin
				shift_digit(b);
				if (digits == 3'd4) begin
					if (hex_invalid) begin
						raise_error(ERR_BAD_LOW_HEX, mark_u);
					end else if (hex_acc[15:10] != SURR_LOW) begin
						raise_error(ERR_LOW_RANGE, next_cursor);
					end else begin
						push_utf8(SUPP_BASE + {1'b0, high_bits, hex_acc[9:0]});
						mode = MODE_PLAIN;
					end
				end
			end
		endcase
	endfunction

	// Works out every result that one accepted item causes.
	function automatic void decode_item(input item_t it);
		int         count_in;
		logic [31:0] next_cursor;
		result_t    tail;
		count_in = decoded_q.size();
		if (at_slice_start) begin
			clear_decoder();
			cursor         = it.start_offset;
			at_slice_start = 1'b0;
		end
		if (it.has_byte) begin
			next_cursor = (cursor == '1) ? cursor : cursor + 32'd1;
			if (!dropping) decode_byte(it.data_byte, next_cursor);
			cursor = next_cursor;
		end
		if (it.slice_last) begin
			if (!dropping) begin
				case (mode)
					MODE_PLAIN: ;
					MODE_ESC: raise_error(ERR_TRUNCATED, cursor);
					MODE_UHEX: raise_error(ERR_SHORT_U, mark_u);
					default: raise_error(ERR_MISSING_LOW, mark_high);
				endcase
			end
			// A slice that ends quietly still gets one marker result.
			if (decoded_q.size() == count_in) push_result(8'h00, 1'b0, ERR_NONE, '0);
			tail             = decoded_q.pop_back();
			tail.result_last = 1'b1;
			decoded_q.push_back(tail);
			at_slice_start = 1'b1;
		end
	endfunction

	function automatic void check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] got_val);
		if (exp_val !== got_val) begin
			$display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, exp_val, got_val);
			fail_total++;
		end
	endfunction

	// Compare the result transfer first: it never belongs to an item taken at this edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_decoder();
			cursor         = '0;
			at_slice_start = 1'b1;
			decoded_q.delete();
			fail_total     = 0;
			mismatches     <= 0;
			pending        <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (decoded_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual byte 0x%0h valid %0b code %0d offset 0x%0h last %0b",
						$time, result_data.out_byte, result_data.out_valid,
						result_data.error_code, result_data.error_offset,
						result_data.result_last);
					fail_total++;
				end else begin
					wanted = decoded_q.pop_front();
					check_field("out_byte", 32'(wanted.out_byte), 32'(result_data.out_byte));
					check_field("out_valid", 32'(wanted.out_valid), 32'(result_data.out_valid));
					check_field("error_code", 32'(wanted.error_code),
						32'(result_data.error_code));
					check_field("error_offset", wanted.error_offset, result_data.error_offset);
					check_field("result_last", 32'(wanted.result_last),
						32'(result_data.result_last));
				end
			end
			if (item_valid && item_ready) decode_item(item_data);
			mismatches <= fail_total;
			pending    <= decoded_q.size();
		end
	end

endmodule

>>> tb/sv/testbench.sv
// Top level: clock, reset, stimulus for the escaped byte stream and the verdict.
module testbench import jsu_pkg::*; ();

	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   mismatches;
	int   pending;
	int   cycle_count = 0;
	int   idle_pct = 0;
	int   stall_pct = 0;
	int   sent_count = 0;

	// Bytes of the slice being built, and the letters of the simple escapes.
	logic [7:0] text_q[$];
	string      esc_letters = "\"\\/bfnrt";

	jsu_stream_if #(.T(item_t))   item_ch ();
	jsu_stream_if #(.T(result_t)) result_ch ();

	json_string_unescape dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	unescape_check u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_ch.valid),
		.item_ready   (item_ch.ready),
		.item_data    (item_ch.payload),
		.result_valid (result_ch.valid),
		.result_ready (result_ch.ready),
		.result_data  (result_ch.payload),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	always #5 clk = ~clk;

	// The receiver stalls at random according to the current phase.
	always @(posedge clk) begin
		result_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Offers one item, idling first at random, and holds it until the transfer.
	task automatic send_item(input logic [7:0] b, input logic has, input logic last,
			input logic [31:0] off);
		while ($urandom_range(99) < idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.payload <= '{data_byte: b, has_byte: has, slice_last: last, start_offset: off};
		item_ch.valid   <= 1'b1;
		do @(posedge clk); while (!item_ch.ready);
		sent_count++;
	endtask

	// Sends text_q as one slice; the start offset only matters on the first item.
	task automatic send_slice(input logic [31:0] off, input bit close_empty);
		bit started;
		int i;
		started = 1'b0;
		for (i = 0; i < text_q.size(); i++) begin
			if ($urandom_range(19) == 0) begin
				send_item(8'($urandom), 1'b0, 1'b0, started ? $urandom() : off);
				started = 1'b1;
			end
			send_item(text_q[i], 1'b1, !close_empty && (i == text_q.size() - 1),
				started ? $urandom() : off);
			started = 1'b1;
		end
		if (close_empty || text_q.size() == 0)
			send_item(8'($urandom), 1'b0, 1'b1, started ? $urandom() : off);
	endtask

	task automatic send_text(input string s, input logic [31:0] off);
		int i;
		text_q.delete();
		for (i = 0; i < s.len(); i++) text_q.push_back(s[i]);
		send_slice(off, 1'b0);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) return "0" + {4'h0, n};
		return ($urandom_range(1) ? "a" : "A") + {4'h0, n} - 8'd10;
	endfunction

	function automatic logic [7:0] non_hex_byte();
		logic [7:0] b;
		do b = 8'($urandom);
		while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F"));
		return b;
	endfunction

	// Ten payload bits of a surrogate, leaning on the ends of the range.
	function automatic logic [9:0] rand_ten();
		case ($urandom_range(3))
			0: return 10'h000;
			1: return 10'h3FF;
			default: return 10'($urandom_range(1023));
		endcase
	endfunction

	// A code point outside the surrogate range, spread over the UTF-8 lengths.
	function automatic logic [15:0] rand_bmp();
		case ($urandom_range(5))
			0: return 16'($urandom_range(16'h7F));
			1: return 16'($urandom_range(16'h7FF, 16'h80));
			2: return 16'($urandom_range(16'hD7FF, 16'h800));
			3: return 16'($urandom_range(16'hFFFF, 16'hE000));
			4: return 16'h0000;
			default: return 16'hFFFF;
		endcase
	endfunction

	task automatic add_u(input logic [15:0] v);
		int i;
		text_q.push_back(CH_BSLASH);
		text_q.push_back(CH_U);
		for (i = 3; i >= 0; i--) text_q.push_back(hex_char(v[i*4 +: 4]));
	endtask

	task automatic add_bad_hex_u();
		add_u(16'($urandom));
		text_q[text_q.size() - 1 - $urandom_range(3)] = non_hex_byte();
	endtask

	task automatic add_pair();
		add_u(16'hD800 | {6'd0, rand_ten()});
		add_u(16'hDC00 | {6'd0, rand_ten()});
	endtask

	task automatic add_clean_token();
		int         roll;
		logic [7:0] b;
		roll = $urandom_range(99);
		if (roll < 35) begin
			case ($urandom_range(9))
				0: b = 8'h00;
				1: b = 8'hFF;
				default: do b = 8'($urandom); while (b == CH_BSLASH);
			endcase
			text_q.push_back(b);
		end else if (roll < 60) begin
			text_q.push_back(CH_BSLASH);
			text_q.push_back(esc_letters[$urandom_range(7)]);
		end else if (roll < 85) begin
			add_u(rand_bmp());
		end else begin
			add_pair();
		end
	endtask

	task automatic add_error_token();
		logic [7:0] b;
		bit         simple;
		int         i;
		case ($urandom_range(5))
			// Escape letter that is not defined.
			0: begin
				do begin
					b      = 8'($urandom);
					simple = (b == CH_U);
					for (i = 0; i < esc_letters.len(); i++)
						if (b == esc_letters[i]) simple = 1'b1;
				end while (simple);
				text_q.push_back(CH_BSLASH);
				text_q.push_back(b);
			end
			1: add_bad_hex_u();
			2: add_u(16'hDC00 | {6'd0, rand_ten()});
			// High surrogate not followed by a backslash and u.
			3: begin
				add_u(16'hD800 | {6'd0, rand_ten()});
				if ($urandom_range(1)) begin
					do b = 8'($urandom); while (b == CH_BSLASH);
					text_q.push_back(b);
				end else begin
					text_q.push_back(CH_BSLASH);
					do b = 8'($urandom); while (b == CH_U);
					text_q.push_back(b);
				end
			end
			4: begin
				add_u(16'hD800 | {6'd0, rand_ten()});
				add_bad_hex_u();
			end
			default: begin
				add_u(16'hD800 | {6'd0, rand_ten()});
				add_u(rand_bmp());
			end
		endcase
	endtask

	// An escape cut short by the end of the slice.
	task automatic add_cut_escape();
		int start_len;
		int cut;
		start_len = text_q.size();
		case ($urandom_range(2))
			0: begin
				text_q.push_back(CH_BSLASH);
				text_q.push_back(esc_letters[$urandom_range(7)]);
			end
			1: add_u(rand_bmp());
			default: add_pair();
		endcase
		cut = $urandom_range(text_q.size() - start_len - 1, 1);
		repeat (cut) text_q.delete(text_q.size() - 1);
	endtask

	// Mostly well-formed slices; some carry one error or end inside an escape.
	task automatic send_random_slice();
		int          tokens;
		int          style;
		int          bad_at;
		int          i;
		logic [31:0] off;
		text_q.delete();
		tokens = $urandom_range(6, 1);
		style  = $urandom_range(99);
		bad_at = (style < 25) ? $urandom_range(tokens - 1) : -1;
		for (i = 0; i < tokens; i++) begin
			if (i == bad_at) add_error_token();
			else add_clean_token();
		end
		if (style >= 85) add_cut_escape();
		if ($urandom_range(7) == 0) off = 32'hFFFF_FFFF - 32'($urandom_range(4));
		else off = $urandom();
		send_slice(off, $urandom_range(9) == 0);
	endtask

	task automatic run_phase(input int idle, input int stall, input int n_items);
		int target;
		idle_pct  = idle;
		stall_pct = stall;
		target    = sent_count + n_items;
		while (sent_count < target) send_random_slice();
	endtask

	initial begin
		item_ch.valid   = 1'b0;
		item_ch.payload = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed slices: four-byte UTF-8 with the cursor saturating, invalid letter,
		// lone low surrogate, missing low surrogate followed by dropped bytes,
		// truncation at a saturated cursor, and an empty slice ending on an empty item.
		send_text("\\uD83D\\uDE00", 32'hFFFF_FFFD);
		send_text("\\q", 32'h0000_0000);
		send_text("\\uDC00", 32'h0000_1000);
		send_text("\\uD800xa", 32'h0000_0010);
		send_text("\\", 32'hFFFF_FFFF);
		text_q.delete();
		send_slice(32'h1234_5678, 1'b1);

		// Random slices over phases of input idling and receiver stalls.
		run_phase(0, 0, 15);
		run_phase(64, 0, 15);
		run_phase(0, 64, 15);
		run_phase(6, 6, 15);

		// Drain: wait for every predicted result, then let the bench idle before the verdict.
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
